@@ sv/pits_pkg.sv @@
`timescale 1ns / 1ps

package pits_pkg;

   // field widths of the command and result items
   localparam int MODE_W     = 3;
   localparam int SLOT_W     = 4;
   localparam int PRIO_W     = 2;
   localparam int TIME_W     = 32;
   localparam int STATUS_W   = 2;

   // default table shape
   localparam int SLOTS_DEFAULT           = 16;
   localparam int PRIORITY_LEVELS_DEFAULT = 4;

   // command codes
   localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DEREGISTER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REQUEUE    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET_PRIO   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SET_IVAL   = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_FIRED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd3;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_OP    = 6'b000010,
      ST_READ  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_FIRE  = 6'b010000,
      ST_END   = 6'b100000
   } state_type;

endpackage

@@ sv/pits_ram.sv @@
`timescale 1ns / 1ps

module pits_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/priority_interval_task_scheduler_top.sv @@
`timescale 1ns / 1ps

// a command item gives its single result through the ST_OP state and the result registers
// a tick item reads and checks each slot in ST_READ and ST_CHECK, passes through ST_FIRE for each
//   due slot and ends in ST_END; scanned levels are min(PRIORITY_LEVELS, 4)
// one item at a time; busy stays high until the item's final result goes out
// the slot tables sit in memories with one shared address, read one slot at a time by the scan sequencer
// reset clears all valid marks at once; results leave as single-cycle strobes, never stalled
module priority_interval_task_scheduler_top #(
   parameter int SLOTS           = pits_pkg::SLOTS_DEFAULT,
   parameter int PRIORITY_LEVELS = pits_pkg::PRIORITY_LEVELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pits_pkg::MODE_W-1:0]    req_mode,
   input  logic [pits_pkg::SLOT_W-1:0]    req_slot_index,
   input  logic [pits_pkg::PRIO_W-1:0]    req_new_priority,
   input  logic [pits_pkg::TIME_W-1:0]    req_new_interval,
   input  logic [pits_pkg::TIME_W-1:0]    req_now_ms,
   output logic                           rsp_valid,
   output logic [pits_pkg::SLOT_W-1:0]    rsp_fired_slot,
   output logic [pits_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_last
);

   import pits_pkg::*;

   localparam int IW       = $clog2(SLOTS);
   // stored priorities are 2 bits wide, so levels past the fourth never match
   localparam int PRIO_MAX = 1 << PRIO_W;
   localparam int NLEV     = (PRIORITY_LEVELS < PRIO_MAX) ? PRIORITY_LEVELS : PRIO_MAX;

   state_type state_ff, state_in;

   // latched item payload
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [TIME_W-1:0] ival_ff, ival_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // scan counters and pending fired slot
   logic [IW-1:0]     slot_ff, slot_in;
   logic [PRIO_W-1:0] level_ff, level_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IW-1:0]     pend_slot_ff, pend_slot_in;

   logic [SLOTS-1:0]  slot_valid_ff, slot_valid_in;

   // result registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // memory ports
   logic [IW-1:0]     ram_addr;
   logic              prio_we, ival_we, last_we;
   logic [TIME_W-1:0] last_wdata;
   logic [PRIO_W-1:0] prio_rd;
   logic [TIME_W-1:0] ival_rd, last_rd;

   // shared adder
   logic [TIME_W-1:0] alu_a, alu_b, alu_sum;
   logic              alu_cin;

   logic              accept;
   logic              idx_in_range;
   logic [IW-1:0]     cmd_addr;
   logic              cmd_mode_ok;
   logic              cmd_slot_valid;
   logic              cmd_write_ok;
   logic              due;
   logic              scan_slot_end;
   logic              scan_level_end;

   assign accept       = start && (state_ff == ST_IDLE);
   assign busy         = (state_ff != ST_IDLE);
   assign idx_in_range = (32'(idx_ff) < 32'(SLOTS));
   assign cmd_addr     = IW'(idx_ff);
   assign cmd_slot_valid = slot_valid_ff[cmd_addr];
   assign cmd_mode_ok  = (mode_ff == MODE_REGISTER) || (mode_ff == MODE_DEREGISTER) ||
                         (mode_ff == MODE_REQUEUE) || (mode_ff == MODE_SET_PRIO) ||
                         (mode_ff == MODE_SET_IVAL);
   assign cmd_write_ok = (state_ff == ST_OP) && cmd_mode_ok && idx_in_range &&
                         ((mode_ff == MODE_REGISTER) || cmd_slot_valid);

   // adder: now - last_run while checking, last_run + interval while firing
   always_comb begin
      if (state_ff == ST_CHECK) begin
         alu_a   = now_ff;
         alu_b   = ~last_rd;
         alu_cin = 1'b1;
      end else begin
         alu_a   = last_rd;
         alu_b   = ival_rd;
         alu_cin = 1'b0;
      end
      alu_sum = alu_a + alu_b + TIME_W'(alu_cin);
   end

   assign due = slot_valid_ff[slot_ff] && (prio_rd == level_ff) && (alu_sum >= ival_rd);
   assign scan_slot_end  = (slot_ff == IW'(SLOTS - 1));
   assign scan_level_end = (level_ff == PRIO_W'(NLEV - 1));

   // memory write control
   assign ram_addr   = (state_ff == ST_OP) ? cmd_addr : slot_ff;
   assign prio_we    = cmd_write_ok &&
                       ((mode_ff == MODE_REGISTER) || (mode_ff == MODE_SET_PRIO));
   assign ival_we    = cmd_write_ok &&
                       ((mode_ff == MODE_REGISTER) || (mode_ff == MODE_SET_IVAL));
   assign last_we    = (state_ff == ST_FIRE) || (cmd_write_ok &&
                       ((mode_ff == MODE_REGISTER) || (mode_ff == MODE_REQUEUE)));
   assign last_wdata = (state_ff == ST_FIRE) ? alu_sum : now_ff;

   pits_ram #(.WIDTH(PRIO_W), .DEPTH(SLOTS)) u_prio_ram (
      .clock   (clock),
      .wr_en   (prio_we),
      .wr_addr (ram_addr),
      .wr_data (prio_ff),
      .rd_addr (ram_addr),
      .rd_data (prio_rd)
   );

   pits_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_ival_ram (
      .clock   (clock),
      .wr_en   (ival_we),
      .wr_addr (ram_addr),
      .wr_data (ival_ff),
      .rd_addr (ram_addr),
      .rd_data (ival_rd)
   );

   pits_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_last_ram (
      .clock   (clock),
      .wr_en   (last_we),
      .wr_addr (ram_addr),
      .wr_data (last_wdata),
      .rd_addr (ram_addr),
      .rd_data (last_rd)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      prio_in       = prio_ff;
      ival_in       = ival_ff;
      now_in        = now_ff;
      slot_in       = slot_ff;
      level_in      = level_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      slot_valid_in = slot_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = '0;
      rsp_status_in = STATUS_FAIL;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in       = req_mode;
               idx_in        = req_slot_index;
               prio_in       = req_new_priority;
               ival_in       = req_new_interval;
               now_in        = req_now_ms;
               slot_in       = '0;
               level_in      = '0;
               pend_valid_in = 1'b0;
               state_in      = (req_mode == MODE_TICK) ? ST_READ : ST_OP;
            end
         end
         ST_OP: begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_status_in = cmd_write_ok ? STATUS_DONE : STATUS_FAIL;
            if (cmd_write_ok && (mode_ff == MODE_REGISTER)) begin
               slot_valid_in[cmd_addr] = 1'b1;
            end
            if (cmd_write_ok && (mode_ff == MODE_DEREGISTER)) begin
               slot_valid_in[cmd_addr] = 1'b0;
            end
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK, ST_FIRE: begin
            if ((state_ff == ST_CHECK) && due) begin
               state_in = ST_FIRE;
            end else begin
               // hand out the previous due slot; this one waits for the last flag
               if (state_ff == ST_FIRE) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_slot_in   = SLOT_W'(pend_slot_ff);
                     rsp_status_in = STATUS_FIRED;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = slot_ff;
               end
               // step to the next slot or level
               if (scan_slot_end) begin
                  slot_in = '0;
                  if (scan_level_end) begin
                     state_in = ST_END;
                  end else begin
                     level_in = level_ff + PRIO_W'(1);
                     state_in = ST_READ;
                  end
               end else begin
                  slot_in  = slot_ff + IW'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_END: begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            if (pend_valid_ff) begin
               rsp_slot_in   = SLOT_W'(pend_slot_ff);
               rsp_status_in = STATUS_FIRED;
            end else begin
               rsp_status_in = STATUS_NONE;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      prio_ff       <= prio_in;
      ival_ff       <= ival_in;
      now_ff        <= now_in;
      slot_ff       <= slot_in;
      level_ff      <= level_in;
      pend_slot_ff  <= pend_slot_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_slot = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

   // the final result of an item goes out as the block turns idle
   a_last_on_idle: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_last))
      else $error("block went idle without a final result");

   // a result that is not final means the item is still in progress
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (busy && (rsp_status == STATUS_FIRED)))
      else $error("non-final result outside a tick scan");

   // accepted items hold the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // slot number is zero unless a slot fired
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_FIRED)) |-> (rsp_fired_slot == '0))
      else $error("slot number set on a non-fired result");

endmodule

@@ verif/tb_priority_interval_task_scheduler_top.sv @@
`timescale 1ns / 1ps

module tb_priority_interval_task_scheduler_top;
   import pits_pkg::*;

   localparam int SLOTS           = SLOTS_DEFAULT;
   localparam int PRIORITY_LEVELS = PRIORITY_LEVELS_DEFAULT;
   localparam int RESET_CYCLES    = 11;
   localparam int STALL_LIMIT     = 4000;
   localparam int TAIL_CYCLES     = 200;
   localparam int RANDOM_ITEMS    = 300;

   // command codes the block does not define
   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
      logic                last;
   } sched_result_type;

   // table model and queue of due results
   class sched_scoreboard;
      bit                  slot_valid [SLOTS];
      logic [PRIO_W-1:0]   slot_prio  [SLOTS];
      logic [TIME_W-1:0]   slot_ival  [SLOTS];
      logic [TIME_W-1:0]   slot_last  [SLOTS];
      sched_result_type    due_q [$];
      int                  errors;
      int                  items;
      int                  results;
      int                  most_fired;
      int                  mode_seen   [1 << MODE_W];
      int                  status_seen [1 << STATUS_W];

      function int pending();
         return due_q.size();
      endfunction

      function void add_due(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] status, logic last);
         sched_result_type r;
         r.slot   = slot;
         r.status = status;
         r.last   = last;
         due_q.push_back(r);
         status_seen[status]++;
      endfunction

      // work out the results one accepted item causes
      function void note_item(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] idx,
                              logic [PRIO_W-1:0] prio, logic [TIME_W-1:0] ival,
                              logic [TIME_W-1:0] now);
         int                fired [$];
         logic [TIME_W-1:0] elapsed;
         logic [STATUS_W-1:0] st;
         items++;
         mode_seen[mode]++;
         if (mode == MODE_TICK) begin
            // scan by level, then by slot index
            for (int lvl = 0; lvl < PRIORITY_LEVELS; lvl++) begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (slot_valid[s] && slot_prio[s] == lvl) begin
                     elapsed = now - slot_last[s];
                     if (elapsed >= slot_ival[s]) begin
                        fired.push_back(s);
                        slot_last[s] = slot_last[s] + slot_ival[s];
                     end
                  end
               end
            end
            if (fired.size() == 0) begin
               add_due('0, STATUS_NONE, 1'b1);
            end else begin
               foreach (fired[k]) add_due(SLOT_W'(fired[k]), STATUS_FIRED, k == fired.size() - 1);
               if (fired.size() > most_fired) most_fired = fired.size();
            end
         end else begin
            st = STATUS_FAIL;
            if (mode <= MODE_SET_IVAL && idx < SLOTS) begin
               if (mode == MODE_REGISTER) begin
                  slot_valid[idx] = 1'b1;
                  slot_prio[idx]  = prio;
                  slot_ival[idx]  = ival;
                  slot_last[idx]  = now;
                  st = STATUS_DONE;
               end else if (slot_valid[idx]) begin
                  case (mode)
                     MODE_DEREGISTER: slot_valid[idx] = 1'b0;
                     MODE_REQUEUE:    slot_last[idx]  = now;
                     MODE_SET_PRIO:   slot_prio[idx]  = prio;
                     default:         slot_ival[idx]  = ival;
                  endcase
                  st = STATUS_DONE;
               end
            end
            add_due('0, st, 1'b1);
         end
      endfunction

      // compare one strobed result with the oldest due one
      function void check_result(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] status,
                                 logic last);
         sched_result_type r;
         results++;
         if (due_q.size() == 0) begin
            $error("unexpected result: fired_slot %0d status %0d last %0b", slot, status, last);
            errors++;
            return;
         end
         r = due_q.pop_front();
         if (slot !== r.slot) begin
            $error("fired_slot mismatch: expected %0d, actual %0d", r.slot, slot);
            errors++;
         end
         if (status !== r.status) begin
            $error("status mismatch: expected %0d, actual %0d", r.status, status);
            errors++;
         end
         if (last !== r.last) begin
            $error("last mismatch: expected %0b, actual %0b", r.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [MODE_W-1:0]   req_mode         = MODE_TICK;
   logic [SLOT_W-1:0]   req_slot_index   = '0;
   logic [PRIO_W-1:0]   req_new_priority = '0;
   logic [TIME_W-1:0]   req_new_interval = '0;
   logic [TIME_W-1:0]   req_now_ms       = '0;
   logic                rsp_valid;
   logic [SLOT_W-1:0]   rsp_fired_slot;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;

   sched_scoreboard     sb;
   logic [TIME_W-1:0]   now_cur;
   int                  stall_count = 0;

   priority_interval_task_scheduler_top #(
      .SLOTS           (SLOTS),
      .PRIORITY_LEVELS (PRIORITY_LEVELS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_slot_index   (req_slot_index),
      .req_new_priority (req_new_priority),
      .req_new_interval (req_new_interval),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_fired_slot   (rsp_fired_slot),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_fired_slot, rsp_status, rsp_last);
   end

   // watchdog on cycles where neither side moves anything
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("watchdog: no item or result for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // present one item and hold it until the block takes it
   task automatic drive_item(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] idx,
                             logic [PRIO_W-1:0] prio, logic [TIME_W-1:0] ival,
                             logic [TIME_W-1:0] now);
      req_mode         <= mode;
      req_slot_index   <= idx;
      req_new_priority <= prio;
      req_new_interval <= ival;
      req_now_ms       <= now;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(mode, idx, prio, ival, now);
   endtask

   task automatic idle_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every due result has come back
   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [TIME_W-1:0] pick_interval();
      int p;
      p = $urandom_range(99);
      if (p < 10) return '0;
      else if (p < 50) return $urandom_range(12, 1);
      else if (p < 80) return $urandom_range(300, 13);
      else if (p < 92) return $urandom;
      else if (p < 96) return '1;
      else return {1'b1, 31'($urandom)};
   endfunction

   // mostly small forward steps, now and then a jump anywhere
   task automatic advance_ms();
      if ($urandom_range(99) < 3) now_cur = $urandom;
      else now_cur = now_cur + $urandom_range(40);
   endtask

   task automatic random_item();
      int                p;
      logic [MODE_W-1:0] mode;
      p = $urandom_range(99);
      if (p < 35) mode = MODE_TICK;
      else if (p < 62) mode = MODE_REGISTER;
      else if (p < 70) mode = MODE_DEREGISTER;
      else if (p < 78) mode = MODE_REQUEUE;
      else if (p < 86) mode = MODE_SET_PRIO;
      else if (p < 96) mode = MODE_SET_IVAL;
      else if (p < 98) mode = MODE_SPARE_A;
      else mode = MODE_SPARE_B;
      advance_ms();
      drive_item(mode, SLOT_W'($urandom), PRIO_W'($urandom), pick_interval(), now_cur);
   endtask

   // fill the whole table with short intervals, then tick
   task automatic fill_and_tick();
      for (int s = 0; s < SLOTS; s++) begin
         drive_item(MODE_REGISTER, SLOT_W'(s), PRIO_W'($urandom), $urandom_range(3), now_cur);
      end
      now_cur = now_cur + $urandom_range(6, 3);
      drive_item(MODE_TICK, '0, '0, '0, now_cur);
   endtask

   initial begin
      int n;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, rejected commands, wrap-around and extremes
      drive_item(MODE_TICK,       4'd0,  2'd0, '0,           '0);
      drive_item(MODE_DEREGISTER, 4'd3,  2'd0, '0,           '0);
      drive_item(MODE_REQUEUE,    4'd3,  2'd0, '0,           '0);
      drive_item(MODE_SET_PRIO,   4'd3,  2'd1, '0,           '0);
      drive_item(MODE_SET_IVAL,   4'd3,  2'd0, 32'd9,        '0);
      drive_item(MODE_SPARE_A,    4'd1,  2'd0, '0,           '0);
      drive_item(MODE_SPARE_B,    4'd15, 2'd3, '1,           '1);
      drive_item(MODE_REGISTER,   4'd0,  2'd0, '0,           '0);
      drive_item(MODE_REGISTER,   4'd15, 2'd3, '1,           '1);
      drive_item(MODE_REGISTER,   4'd5,  2'd2, 32'd100,      32'hFFFF_FFF0);
      drive_item(MODE_REGISTER,   4'd0,  2'd1, '0,           32'd5);
      drive_item(MODE_TICK,       4'd0,  2'd0, '0,           32'd50);
      drive_item(MODE_TICK,       4'd0,  2'd0, '0,           32'd200);
      drive_item(MODE_SET_PRIO,   4'd5,  2'd0, '0,           32'd200);
      drive_item(MODE_SET_IVAL,   4'd15, 2'd0, '0,           32'd200);
      drive_item(MODE_TICK,       4'd0,  2'd0, '0,           32'd201);
      drive_item(MODE_REQUEUE,    4'd5,  2'd0, '0,           32'd1000);
      drive_item(MODE_REGISTER,   4'd10, 2'd0, 32'd7,        32'd1000);
      drive_item(MODE_TICK,       4'd0,  2'd0, '0,           32'd1007);
      drive_item(MODE_DEREGISTER, 4'd0,  2'd0, '0,           32'd1007);
      drive_item(MODE_TICK,       4'd0,  2'd0, '0,           32'd1007);
      drive_item(MODE_SET_IVAL,   4'd15, 2'd0, '1,           32'd1008);
      drive_item(MODE_TICK,       4'd0,  2'd0, '0,           32'd1008);
      wait_all_results();

      // random: start just below the wrap point
      now_cur = 32'hFFFF_FC00;
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n % 75 == 0) begin
            fill_and_tick();
            n += SLOTS + 1;
         end else begin
            random_item();
            n++;
         end
         if (n % 60 == 0) wait_all_results();
         // a long stretch runs back to back
         if ((n < 120 || n >= 200) && $urandom_range(99) < 7) idle_sender($urandom_range(5, 1));
      end

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d ticks, %0d registers, %0d rejected, %0d results checked",
               sb.items, sb.mode_seen[MODE_TICK], sb.mode_seen[MODE_REGISTER],
               sb.status_seen[STATUS_FAIL], sb.results);
      $display("slot firings %0d, most in one tick %0d, empty ticks %0d",
               sb.status_seen[STATUS_FIRED], sb.most_fired, sb.status_seen[STATUS_NONE]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/pits_pkg.sv
sv/pits_ram.sv
sv/priority_interval_task_scheduler_top.sv
verif/tb_priority_interval_task_scheduler_top.sv
